// ===== hw/rtl/lbbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbc_pkg
// Shared types and constants of the block buffer cache tag engine.
// ----------------------------------------------------------------------------
package lbbc_pkg;

  // Field widths of the request and response
  localparam int unsigned FS_W    = 8;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned BLOCK_W = 23;
  localparam int unsigned SLOT_W  = 4;

  // Parameter defaults
  localparam int unsigned SLOT_COUNT_DEF       = 16;
  localparam int unsigned BLOCK_BYTES_LOG2_DEF = 9;

  // Access codes
  localparam logic OPC_READ  = 1'b0;
  localparam logic OPC_WRITE = 1'b1;

  // One access request
  typedef struct packed {
    logic             opcode;
    logic [FS_W-1:0]  fs_id;
    logic [POS_W-1:0] position;
  } req_t;

  // One lookup result
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               fetch;
    logic [BLOCK_W-1:0] block_number;
    logic               writeback;
    logic [FS_W-1:0]    victim_fs_id;
    logic [BLOCK_W-1:0] victim_block;
  } rsp_t;

  // Tag entry held by one recency cell
  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [FS_W-1:0]    fs_id;
    logic [BLOCK_W-1:0] block;
  } entry_t;

endpackage

// ===== hw/rtl/lbbc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbc_cell
// One position of the recency stack: holds a slot index and its tag entry,
// compares the tag against the lookup key, and takes its upper neighbor's
// contents when the stack closes up above a removed position.
// ----------------------------------------------------------------------------
module lbbc_cell
  import lbbc_pkg::*;
#(
  parameter int unsigned IdxW  = 4,
  parameter int unsigned Index = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic [FS_W-1:0]    key_fs_i,
  input  logic [BLOCK_W-1:0] key_block_i,
  input  entry_t             next_i,
  input  logic [IdxW-1:0]    next_idx_i,
  output entry_t             entry_o,
  output logic [IdxW-1:0]    idx_o,
  output logic               match_o
);

  logic               valid_q;
  logic               dirty_q;
  logic [FS_W-1:0]    fs_q;
  logic [BLOCK_W-1:0] block_q;
  logic [IdxW-1:0]    idx_q;

  // Control part: valid, dirty and slot index reset to the initial order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      idx_q   <= IdxW'(Index);
    end else if (shift_i) begin
      valid_q <= next_i.valid;
      dirty_q <= next_i.dirty;
      idx_q   <= next_idx_i;
    end
  end

  // Tag payload: only read while valid
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      fs_q    <= next_i.fs_id;
      block_q <= next_i.block;
    end
  end

  // Compare against the lookup key
  assign match_o = valid_q && (fs_q == key_fs_i) && (block_q == key_block_i);

  assign entry_o = {valid_q, dirty_q, fs_q, block_q};
  assign idx_o   = idx_q;

endmodule

// ===== hw/rtl/lru_block_buffer_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_top
// Tag and LRU replacement engine of a write-back disk block buffer cache.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i and raise start; the request is taken at a
//   rising edge where start is high and busy is low. busy is high for the
//   one lookup cycle that follows.
//   Response channel: done_o is high for exactly one cycle with rsp_o; the
//   receiver cannot stall it and must take it in that cycle.
//   Sequence: the key is captured and busy raised at the request edge; the
//   cells compare while busy is high, and the edge that ends the busy cycle
//   updates the stack and registers rsp_o together with done_o.
//   Back-to-back: a new request is not taken while busy is high, during
//   the compare-and-shift cycle of the cell chain.
//   The cells form a recency stack, least recent at cell 0, most recent at
//   the top. A hit removes its cell, a miss removes cell 0 (a never used
//   slot while any remain, else the LRU slot), and the chain closes up
//   while the accessed slot enters at the top.
//   Reset: all slots invalid and clean, stack order is slot 0 up to the
//   last slot; no clearing pass, the block is ready right after reset.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_top
  import lbbc_pkg::*;
#(
  parameter int unsigned SlotCount      = SLOT_COUNT_DEF,
  parameter int unsigned BlockBytesLog2 = BLOCK_BYTES_LOG2_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(SlotCount);

  logic               busy_q;
  logic               done_q;
  logic               opcode_q;
  logic [FS_W-1:0]    fs_q;
  logic [BLOCK_W-1:0] blk_q;
  rsp_t               rsp_q;
  rsp_t               rsp_d;

  entry_t             entries [SlotCount];
  logic [IdxW-1:0]    idxs    [SlotCount];
  logic [SlotCount-1:0] match;
  logic [SlotCount-1:0] sel;
  logic [SlotCount-1:0] shift;
  logic               hit;
  logic [IdxW-1:0]    sel_idx;
  logic               sel_dirty;
  entry_t             top_entry;
  logic [SLOT_W+IdxW-1:0] slot_ext;

  // Capture the request and track the lookup cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start && !busy_q;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      opcode_q <= req_i.opcode;
      fs_q     <= req_i.fs_id;
      blk_q    <= BLOCK_W'(req_i.position >> BlockBytesLog2);
    end
  end

  assign busy = busy_q;

  // Chain of recency cells
  for (genvar i = 0; i < SlotCount; i++) begin : g_cell
    entry_t          nb_entry;
    logic [IdxW-1:0] nb_idx;

    if (i == SlotCount - 1) begin : g_top
      assign nb_entry = top_entry;
      assign nb_idx   = sel_idx;
    end else begin : g_mid
      assign nb_entry = entries[i+1];
      assign nb_idx   = idxs[i+1];
    end

    // Close up every cell at or above the removed position
    assign shift[i] = busy_q && (|sel[i:0]);

    lbbc_cell #(
      .IdxW  (IdxW),
      .Index (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift[i]),
      .key_fs_i    (fs_q),
      .key_block_i (blk_q),
      .next_i      (nb_entry),
      .next_idx_i  (nb_idx),
      .entry_o     (entries[i]),
      .idx_o       (idxs[i]),
      .match_o     (match[i])
    );
  end

  // Pick the removed cell: the matching one on a hit, else the bottom one
  assign hit = |match;
  assign sel = hit ? match : SlotCount'(1);

  always_comb begin
    sel_idx   = '0;
    sel_dirty = 1'b0;
    for (int i = 0; i < SlotCount; i++) begin
      if (sel[i]) begin
        sel_idx   = sel_idx | idxs[i];
        sel_dirty = sel_dirty | entries[i].dirty;
      end
    end
  end

  // Entry pushed on top of the stack
  always_comb begin
    top_entry.valid = 1'b1;
    top_entry.dirty = (hit && sel_dirty) || (opcode_q == OPC_WRITE);
    top_entry.fs_id = fs_q;
    top_entry.block = blk_q;
  end

  // Build the response
  assign slot_ext = {{SLOT_W{1'b0}}, sel_idx};

  always_comb begin
    rsp_d              = '0;
    rsp_d.hit          = hit;
    rsp_d.slot         = slot_ext[SLOT_W-1:0];
    rsp_d.fetch        = !hit && (opcode_q == OPC_READ);
    rsp_d.block_number = blk_q;
    if (!hit && entries[0].valid && entries[0].dirty) begin
      rsp_d.writeback    = 1'b1;
      rsp_d.victim_fs_id = entries[0].fs_id;
      rsp_d.victim_block = entries[0].block;
    end
  end

  // Hold the response for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block buffer cache tag and LRU engine.
// A queue of access requests feeds a clocked driver that raises start with
// random idle cycles. A clocked monitor updates a local tag store and LRU
// order on every accepted request. Each done_o response is compared field
// by field with the oldest predicted response.
// ----------------------------------------------------------------------------
module tb_top;
  import lbbc_pkg::*;

  localparam int unsigned SLOTS     = SLOT_COUNT_DEF;
  localparam int unsigned SHIFT     = BLOCK_BYTES_LOG2_DEF;
  localparam int          HOT_KEYS  = 24;
  localparam int          RAND_REQS = 1500;
  localparam int          MAX_CYCLES = 200000;

  // One queued access plus its driving hints
  typedef struct {
    req_t req;
    bit   drain_first;
    bit   may_idle;
  } access_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;

  access_t pending_q[$];
  rsp_t    predicted_q[$];
  logic    req_taken = 1'b0;
  int      err_cnt = 0;
  int      hit_cnt = 0;
  int      fetch_cnt = 0;
  int      wb_cnt = 0;
  int      req_cnt = 0;

  // Local copy of the tag store and the recency order
  logic               tag_valid [SLOTS];
  logic               tag_dirty [SLOTS];
  logic [FS_W-1:0]    tag_fs    [SLOTS];
  logic [BLOCK_W-1:0] tag_blk   [SLOTS];
  int                 lru_order [SLOTS];
  int                 slots_filled;

  // Working set of keys for the random phase
  logic [FS_W-1:0]    hot_fs  [HOT_KEYS];
  logic [BLOCK_W-1:0] hot_blk [HOT_KEYS];

  lru_block_buffer_cache_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Look up and update the local tag store for one access
  function automatic rsp_t cache_lookup(req_t rq);
    rsp_t               r;
    logic [POS_W-1:0]   shifted;
    logic [BLOCK_W-1:0] blk;
    int                 s;
    int                 p;
    bit                 found;
    r = '0;
    shifted = rq.position >> SHIFT;
    blk = shifted[BLOCK_W-1:0];
    found = 1'b0;
    s = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && tag_valid[i] && tag_fs[i] == rq.fs_id && tag_blk[i] == blk) begin
        found = 1'b1;
        s = i;
      end
    end
    if (!found) begin
      if (slots_filled < SLOTS) begin
        s = slots_filled;
        slots_filled++;
      end else begin
        s = lru_order[0];
        if (tag_valid[s] && tag_dirty[s]) begin
          r.writeback = 1'b1;
          r.victim_fs_id = tag_fs[s];
          r.victim_block = tag_blk[s];
        end
      end
      tag_valid[s] = 1'b1;
      tag_fs[s] = rq.fs_id;
      tag_blk[s] = blk;
      tag_dirty[s] = 1'b0;
      r.fetch = (rq.opcode == OPC_READ);
    end
    if (rq.opcode == OPC_WRITE) begin
      tag_dirty[s] = 1'b1;
    end
    // Move the accessed slot to the most recent end
    p = 0;
    while (p < SLOTS && lru_order[p] != s) p++;
    for (int j = p; j < SLOTS - 1; j++) lru_order[j] = lru_order[j + 1];
    lru_order[SLOTS - 1] = s;
    r.hit = found;
    r.slot = SLOT_W'(s);
    r.block_number = blk;
    hit_cnt += found;
    fetch_cnt += r.fetch;
    wb_cnt += r.writeback;
    return r;
  endfunction

  task automatic compare_rsp(rsp_t want, rsp_t got);
    if (got.hit !== want.hit) begin
      $error("hit: expected %0d, got %0d", want.hit, got.hit);
      err_cnt++;
    end
    if (got.slot !== want.slot) begin
      $error("slot: expected %0d, got %0d", want.slot, got.slot);
      err_cnt++;
    end
    if (got.fetch !== want.fetch) begin
      $error("fetch: expected %0d, got %0d", want.fetch, got.fetch);
      err_cnt++;
    end
    if (got.block_number !== want.block_number) begin
      $error("block_number: expected 0x%0h, got 0x%0h", want.block_number,
             got.block_number);
      err_cnt++;
    end
    if (got.writeback !== want.writeback) begin
      $error("writeback: expected %0d, got %0d", want.writeback, got.writeback);
      err_cnt++;
    end
    if (got.victim_fs_id !== want.victim_fs_id) begin
      $error("victim_fs_id: expected 0x%0h, got 0x%0h", want.victim_fs_id,
             got.victim_fs_id);
      err_cnt++;
    end
    if (got.victim_block !== want.victim_block) begin
      $error("victim_block: expected 0x%0h, got 0x%0h", want.victim_block,
             got.victim_block);
      err_cnt++;
    end
  endtask

  task automatic add_access(logic opc, logic [FS_W-1:0] fs, logic [POS_W-1:0] pos,
                            bit drain, bit idle_ok);
    access_t a;
    a.req.opcode = opc;
    a.req.fs_id = fs;
    a.req.position = pos;
    a.drain_first = drain;
    a.may_idle = idle_ok;
    pending_q.push_back(a);
  endtask

  task automatic new_hot_key(int k);
    hot_fs[k] = ($urandom_range(0, 3) == 0) ? FS_W'($urandom) : FS_W'($urandom_range(0, 3));
    hot_blk[k] = BLOCK_W'($urandom);
  endtask

  // Drive requests at the falling edge; hold a request until it is taken
  always @(negedge clk_i) begin : driver
    bit go;
    access_t nxt;
    if (rst_ni && !(start && !req_taken)) begin
      go = 1'b0;
      if (pending_q.size() > 0) begin
        if (pending_q[0].drain_first && predicted_q.size() != 0) begin
          go = 1'b0;
        end else if (pending_q[0].may_idle && $urandom_range(0, 99) < 26) begin
          go = 1'b0;
        end else begin
          go = 1'b1;
        end
      end
      if (go) begin
        nxt = pending_q.pop_front();
        req_i <= nxt.req;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Sample at the rising edge: check responses, then predict new requests
  always @(posedge clk_i) begin : monitor
    rsp_t want;
    if (rst_ni) begin
      req_taken <= start && !busy;
      if (done_o) begin
        if (predicted_q.size() == 0) begin
          $error("response with no request outstanding");
          err_cnt++;
        end else begin
          want = predicted_q.pop_front();
          compare_rsp(want, rsp_o);
        end
      end
      if (start && !busy) begin
        predicted_q.push_back(cache_lookup(req_i));
        req_cnt++;
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    repeat (MAX_CYCLES) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : main
    int k;
    logic opc;
    for (int i = 0; i < SLOTS; i++) begin
      tag_valid[i] = 1'b0;
      tag_dirty[i] = 1'b0;
      tag_fs[i] = '0;
      tag_blk[i] = '0;
      lru_order[i] = i;
    end
    slots_filled = 0;

    // Directed: extremes, hits on clean and dirty slots, fills, evictions
    add_access(OPC_READ, 8'h00, 32'h0000_0000, 1'b0, 1'b1);
    add_access(OPC_WRITE, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    add_access(OPC_READ, 8'hFF, 32'hFFFF_FE00, 1'b0, 1'b1);
    add_access(OPC_WRITE, 8'h00, 32'h0000_01FF, 1'b0, 1'b1);
    add_access(OPC_READ, 8'h01, 32'h0000_0000, 1'b0, 1'b1);
    for (int i = 0; i < 13; i++) begin
      add_access(logic'(i % 2), FS_W'(16 + i), 32'h1357_9BDF * (i + 1), 1'b0, 1'b1);
    end
    // Cache is full: evict dirty LRU, another dirty one, then a clean one
    add_access(OPC_READ, 8'h02, 32'h8000_0000, 1'b0, 1'b1);
    add_access(OPC_WRITE, 8'h03, 32'h7FFF_FFFF, 1'b0, 1'b1);
    add_access(OPC_WRITE, 8'h04, 32'h5555_5555, 1'b0, 1'b1);
    add_access(OPC_READ, 8'h03, 32'h7FFF_FE00, 1'b0, 1'b1);

    // Random: mostly a working set a bit larger than the cache, some noise
    for (int i = 0; i < HOT_KEYS; i++) new_hot_key(i);
    for (int i = 0; i < RAND_REQS; i++) begin
      opc = logic'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 80) begin
        k = $urandom_range(0, HOT_KEYS - 1);
        if ($urandom_range(0, 99) < 4) new_hot_key(k);
        add_access(opc, hot_fs[k], {hot_blk[k], 9'($urandom)},
                   (i == 0) || (i == 1000), !(i >= 300 && i < 600));
      end else begin
        add_access(opc, FS_W'($urandom), $urandom,
                   (i == 0) || (i == 1000), !(i >= 300 && i < 600));
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_q.size() == 0 && !start);
    wait (predicted_q.size() == 0);
    repeat (4) @(posedge clk_i);

    $display("Ran %0d accesses: %0d hits, %0d fetches, %0d dirty evictions.",
             req_cnt, hit_cnt, fetch_cnt, wb_cnt);
    $display("Directed extremes, fills, clean/dirty evictions, then a hot working set.");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== lru_block_buffer_cache_top.f =====
hw/rtl/lbbc_pkg.sv
hw/rtl/lbbc_cell.sv
hw/rtl/lru_block_buffer_cache_top.sv
tb/tb_top.sv
